/* src/thl_pkg.sv */
// ----------------------------------------------------------------------------
// thl_pkg
// Shared types and constants for the target-code hinge loss unit.
// ----------------------------------------------------------------------------
package thl_pkg;

    localparam int TBL_AW    = 16;
    localparam int TBL_DEPTH = 65536;
    localparam int DIV_NW    = 64;
    localparam int DIV_DW    = 32;
    localparam int CFG_AW    = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ELEM  = 1'b1;

    localparam logic [1:0] REG_MARGIN = 2'd0;
    localparam logic [1:0] REG_BATCH  = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    localparam logic [31:0] MARGIN_RST = 32'd32768;
    localparam logic [10:0] BATCH_RST  = 11'd1;
    localparam logic [8:0]  LENGTH_RST = 9'd255;

    typedef struct packed {
        logic               operation;
        logic [7:0]         class_index;
        logic [7:0]         code_position;
        logic signed [31:0] value;
        logic               batch_end;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] gradient;
        logic signed [31:0] loss;
        logic               loss_valid;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] gt;
        logic               batch_end;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL,
        BK_HINGE,
        BK_GDIV,
        BK_LSTART,
        BK_LDIV,
        BK_DONE
    } t_bk_state;

endpackage

/* src/thl_ram.sv */
// ----------------------------------------------------------------------------
// thl_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module thl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/thl_div.sv */
// ----------------------------------------------------------------------------
// thl_div
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module thl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [thl_pkg::DIV_NW-1:0]  i_dividend,
    input  logic [thl_pkg::DIV_DW-1:0]  i_divisor,
    output logic                        o_done,
    output logic [thl_pkg::DIV_NW-1:0]  o_quot
);

    localparam int CW = $clog2(thl_pkg::DIV_NW);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [thl_pkg::DIV_NW-1:0]  r_quot;
    logic [thl_pkg::DIV_DW-1:0]  r_rem;
    logic [thl_pkg::DIV_DW-1:0]  r_dvs;
    logic [thl_pkg::DIV_DW:0]    n_trial;
    logic                        n_bit;

    always_comb begin
        n_trial = {r_rem, r_quot[thl_pkg::DIV_NW-1]};
        n_bit   = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[thl_pkg::DIV_NW-2:0], n_bit};
            if (n_bit) begin
                r_rem <= thl_pkg::DIV_DW'(n_trial - {1'b0, r_dvs});
            end else begin
                r_rem <= n_trial[thl_pkg::DIV_DW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* src/thl_queue.sv */
// ----------------------------------------------------------------------------
// thl_queue
// Two-entry queue of classified jobs between front and back.
// ----------------------------------------------------------------------------
module thl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  thl_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output thl_pkg::t_job o_job
);

    thl_pkg::t_job r_slot [2];
    logic          r_wptr;
    logic          r_rptr;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_slot[r_rptr];

endmodule

/* src/thl_front.sv */
// ----------------------------------------------------------------------------
// thl_front
// Accepts requests, writes or reads the code table, queues element jobs.
// ----------------------------------------------------------------------------
module thl_front #(
    parameter int MAX_CODE_LEN = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  thl_pkg::t_in_item i_item,
    output logic              o_full,
    output logic              o_q_push,
    output thl_pkg::t_job     o_q_job,
    input  logic              i_q_full
);

    logic                       r_pend;
    logic signed [31:0]         r_value;
    logic                       r_last;
    logic [thl_pkg::TBL_AW-1:0] r_addr;
    logic                       n_acc;
    logic [31:0]                n_lin;
    logic [thl_pkg::TBL_AW-1:0] n_addr;
    logic                       n_we;
    logic [31:0]                n_gt;

    always_comb begin
        n_acc  = i_push && !r_pend;
        n_lin  = 32'(i_item.class_index) * 32'(MAX_CODE_LEN) + 32'(i_item.code_position);
        n_addr = r_pend ? r_addr : n_lin[thl_pkg::TBL_AW-1:0];
        n_we   = n_acc && (i_item.operation == thl_pkg::OP_WRITE);
    end

    thl_ram #(
        .WIDTH (32),
        .DEPTH (thl_pkg::TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_addr  (n_addr),
        .i_wdata (i_item.value),
        .o_rdata (n_gt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (n_acc && i_item.operation == thl_pkg::OP_ELEM) begin
            r_pend <= 1'b1;
        end else if (r_pend && !i_q_full) begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_acc) begin
            r_value <= i_item.value;
            r_last  <= i_item.batch_end;
            r_addr  <= n_lin[thl_pkg::TBL_AW-1:0];
        end
    end

    assign o_full            = r_pend;
    assign o_q_push          = r_pend && !i_q_full;
    assign o_q_job.value     = r_value;
    assign o_q_job.gt        = n_gt;
    assign o_q_job.batch_end = r_last;

endmodule

/* src/thl_back.sv */
// ----------------------------------------------------------------------------
// thl_back
// Computes hinge, running sum, gradient and batch loss for queued jobs.
// ----------------------------------------------------------------------------
module thl_back #(
    parameter int MAX_CODE_LEN = 256,
    parameter int MAX_BATCH    = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  thl_pkg::t_job      i_q_job,
    output logic               o_q_pop,
    input  logic signed [31:0] i_margin,
    input  logic [10:0]        i_batch,
    input  logic [8:0]         i_length,
    input  logic               i_out_free,
    output logic               o_out_load,
    output thl_pkg::t_out_item o_out
);

    thl_pkg::t_bk_state r_state;
    thl_pkg::t_bk_state n_state;

    logic signed [31:0] r_p;
    logic signed [31:0] r_gt;
    logic               r_last;
    logic signed [31:0] r_c;
    logic signed [31:0] r_d;
    logic signed [63:0] r_prod;
    logic [63:0]        r_sum;
    logic signed [31:0] r_grad;
    logic signed [31:0] r_loss;

    logic [31:0]                 n_div;
    logic [31:0]                 n_len;
    logic [31:0]                 n_dl;
    logic signed [33:0]          n_cw;
    logic signed [33:0]          n_dw;
    logic signed [48:0]          n_t;
    logic [30:0]                 n_h;
    logic [63:0]                 n_s;
    logic [31:0]                 n_cabs;
    logic                        n_start;
    logic [thl_pkg::DIV_NW-1:0]  n_dvd;
    logic [thl_pkg::DIV_DW-1:0]  n_dvs;
    logic                        w_done;
    logic [thl_pkg::DIV_NW-1:0]  w_quot;
    logic [40:0]                 n_qc;
    logic signed [42:0]          n_lw;
    logic signed [31:0]          n_loss;
    logic signed [32:0]          n_gq;

    always_comb begin
        if (32'(i_batch) < 32'd1) begin
            n_div = 32'd1;
        end else if (32'(i_batch) > 32'(MAX_BATCH)) begin
            n_div = 32'(MAX_BATCH);
        end else begin
            n_div = 32'(i_batch);
        end
        if (32'(i_length) < 32'd1) begin
            n_len = 32'd1;
        end else if (32'(i_length) > 32'(MAX_CODE_LEN)) begin
            n_len = 32'(MAX_CODE_LEN);
        end else begin
            n_len = 32'(i_length);
        end
        n_dl = n_div * n_len;

        n_cw = 34'sd65536 - (34'(r_gt) <<< 1);
        n_dw = 34'(r_p) - 34'sd32768;

        n_t = 49'(i_margin) + 49'($signed(r_prod[63:16]));
        if (n_t < 0) begin
            n_h = '0;
        end else if (n_t > 49'sd2147483647) begin
            n_h = '1;
        end else begin
            n_h = n_t[30:0];
        end
        n_s = r_sum + 64'(n_h);
        if (n_s[63]) begin
            n_s = {1'b0, {63{1'b1}}};
        end

        n_cabs = r_c[31] ? 32'(-33'(r_c)) : 32'(r_c);
        n_gq   = 33'(w_quot[31:0]);
        if (r_c[31]) begin
            n_gq = -n_gq;
        end

        if (w_quot > 64'd1 << 40) begin
            n_qc = 41'd1 << 40;
        end else begin
            n_qc = w_quot[40:0];
        end
        n_lw = 43'sd32768 - 43'(i_margin) + $signed({2'b0, n_qc});
        if (n_lw > 43'sd2147483647) begin
            n_loss = 32'sh7fffffff;
        end else if (n_lw < -43'sd2147483648) begin
            n_loss = 32'sh80000000;
        end else begin
            n_loss = n_lw[31:0];
        end
    end

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        o_out_load = 1'b0;
        n_start    = 1'b0;
        n_dvd      = 64'(n_cabs);
        n_dvs      = n_div;
        unique case (r_state)
            thl_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_state = thl_pkg::BK_PREP;
                end
            end
            thl_pkg::BK_PREP:  n_state = thl_pkg::BK_MUL;
            thl_pkg::BK_MUL:   n_state = thl_pkg::BK_HINGE;
            thl_pkg::BK_HINGE: begin
                if (n_h != '0) begin
                    n_start = 1'b1;
                    n_state = thl_pkg::BK_GDIV;
                end else begin
                    n_state = thl_pkg::BK_LSTART;
                end
            end
            thl_pkg::BK_GDIV: begin
                if (w_done) begin
                    n_state = thl_pkg::BK_LSTART;
                end
            end
            thl_pkg::BK_LSTART: begin
                n_dvd = r_sum;
                n_dvs = n_dl;
                if (r_last) begin
                    n_start = 1'b1;
                    n_state = thl_pkg::BK_LDIV;
                end else begin
                    n_state = thl_pkg::BK_DONE;
                end
            end
            thl_pkg::BK_LDIV: begin
                if (w_done) begin
                    n_state = thl_pkg::BK_DONE;
                end
            end
            thl_pkg::BK_DONE: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = thl_pkg::BK_IDLE;
                end
            end
            default: n_state = thl_pkg::BK_IDLE;
        endcase
    end

    thl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_start),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= thl_pkg::BK_IDLE;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == thl_pkg::BK_HINGE) begin
                r_sum <= n_s;
            end else if (r_state == thl_pkg::BK_LDIV && w_done) begin
                r_sum <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            thl_pkg::BK_IDLE: begin
                r_p    <= i_q_job.value;
                r_gt   <= i_q_job.gt;
                r_last <= i_q_job.batch_end;
                r_grad <= '0;
                r_loss <= '0;
            end
            thl_pkg::BK_PREP: begin
                if (n_cw > 34'sd2147483647) begin
                    r_c <= 32'sh7fffffff;
                end else if (n_cw < -34'sd2147483648) begin
                    r_c <= 32'sh80000000;
                end else begin
                    r_c <= n_cw[31:0];
                end
                if (n_dw < -34'sd2147483648) begin
                    r_d <= 32'sh80000000;
                end else begin
                    r_d <= n_dw[31:0];
                end
            end
            thl_pkg::BK_MUL: r_prod <= r_d * r_c;
            thl_pkg::BK_GDIV: begin
                if (w_done) begin
                    r_grad <= n_gq[31:0];
                end
            end
            thl_pkg::BK_LDIV: begin
                if (w_done) begin
                    r_loss <= n_loss;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.gradient   = r_grad;
    assign o_out.loss       = r_loss;
    assign o_out.loss_valid = r_last;

endmodule

/* src/target_code_hinge_loss_unit.sv */
// ----------------------------------------------------------------------------
// target_code_hinge_loss_unit
// Target-code hinge loss with gradient and batch loss, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A code table write goes into the table in the cycle it is accepted. A prediction
// element reads its table entry in the front and moves to the back through a
// two-entry queue, so the front keeps taking requests while the back works on
// one element at a time. A nonzero hinge adds the gradient division, and the
// last element of a batch adds the batch loss division. Each division runs in
// a bit-serial divider, one quotient bit per cycle over 64 bits. The back
// starts a new element only after the last one's result is loaded into the
// output register. Results wait in an output register; the back holds while
// that register is full and not popped, and the input stalls once the queue
// and the front are full.
module target_code_hinge_loss_unit #(
    parameter int MAX_CODE_LEN = 256,
    parameter int MAX_BATCH    = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  thl_pkg::t_in_item           i_item,
    output logic                        empty,
    input  logic                        pop,
    output thl_pkg::t_out_item          o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [thl_pkg::CFG_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic signed [31:0] r_margin;
    logic [10:0]        r_batch;
    logic [8:0]         r_length;
    logic               r_out_valid;
    thl_pkg::t_out_item r_out;

    logic               w_q_push;
    thl_pkg::t_job      w_q_in;
    logic               w_q_full;
    logic               w_q_pop;
    logic               w_q_empty;
    thl_pkg::t_job      w_q_out;
    logic               w_out_free;
    logic               w_out_load;
    thl_pkg::t_out_item w_out;
    logic               n_cfg_we;

    assign pready   = 1'b1;
    assign n_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= thl_pkg::MARGIN_RST;
            r_batch  <= thl_pkg::BATCH_RST;
            r_length <= thl_pkg::LENGTH_RST;
        end else if (n_cfg_we) begin
            unique case (paddr[3:2])
                thl_pkg::REG_MARGIN: r_margin <= pwdata;
                thl_pkg::REG_BATCH:  r_batch  <= pwdata[10:0];
                thl_pkg::REG_LENGTH: r_length <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            thl_pkg::REG_MARGIN: prdata = r_margin;
            thl_pkg::REG_BATCH:  prdata = 32'(r_batch);
            thl_pkg::REG_LENGTH: prdata = 32'(r_length);
            default:             prdata = '0;
        endcase
    end

    thl_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .o_q_push (w_q_push),
        .o_q_job  (w_q_in),
        .i_q_full (w_q_full)
    );

    thl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_job   (w_q_out)
    );

    thl_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .MAX_BATCH    (MAX_BATCH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_job    (w_q_out),
        .o_q_pop    (w_q_pop),
        .i_margin   (r_margin),
        .i_batch    (r_batch),
        .i_length   (r_length),
        .i_out_free (w_out_free),
        .o_out_load (w_out_load),
        .o_out      (w_out)
    );

    assign w_out_free = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out;
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule

/* tb/tb_target_code_hinge_loss_unit.sv */
// ----------------------------------------------------------------------------
// tb_target_code_hinge_loss_unit
// Self-checking bench for the target-code hinge loss unit: loads code table
// rows, streams prediction elements under several register settings with
// random idling on both sides, and checks every gradient and batch loss
// against a cycle-free Q16.16 predictor or fixed expected values.
// ----------------------------------------------------------------------------
module tb_target_code_hinge_loss_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam int         LIMIT      = 1500000;
    localparam int         SETTLE     = 200;
    localparam longint    S32_MAX    = 64'sd2147483647;
    localparam longint    S32_MIN    = -64'sd2147483648;
    localparam longint unsigned SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        thl_pkg::t_in_item  it;
        bit                 typed;
        thl_pkg::t_out_item want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    thl_pkg::t_in_item i_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    thl_pkg::t_out_item o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [thl_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    target_code_hinge_loss_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] margin_reg = thl_pkg::MARGIN_RST;
    logic [10:0]        batch_reg  = thl_pkg::BATCH_RST;
    logic [8:0]         length_reg = thl_pkg::LENGTH_RST;
    logic signed [31:0] code_mem [thl_pkg::TBL_DEPTH];
    bit                 written [thl_pkg::TBL_DEPTH];
    logic [15:0]        written_addrs [$];
    longint unsigned    hinge_acc = 0;

    thl_pkg::t_out_item grad_loss_q [$];
    t_row      rows [$];
    int        errors = 0;
    int        n_elem = 0, n_wr = 0, n_loss = 0, n_checked = 0;
    int        cyc = 0;
    int        hold_left = 0;
    int        gap_left = 0;
    bit        no_idle = 1'b0;

    function automatic longint sat32(input longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic bit hinge_predict(input thl_pkg::t_in_item it,
                                         output thl_pkg::t_out_item r);
        logic [15:0]     a;
        longint          gt, c, d, t, h, g, dv, ln, ls;
        longint unsigned q;
        a = {it.class_index, it.code_position};
        r = '0;
        if (it.operation == thl_pkg::OP_WRITE) begin
            code_mem[a] = it.value;
            if (!written[a]) written_addrs.insert(written_addrs.size(), a);
            written[a] = 1'b1;
            return 1'b0;
        end
        dv = batch_reg;
        if (dv < 1) dv = 1;
        if (dv > 1024) dv = 1024;
        ln = length_reg;
        if (ln < 1) ln = 1;
        if (ln > 256) ln = 256;
        gt = code_mem[a];
        c = sat32(64'sd65536 - 2 * gt);
        d = sat32(longint'(it.value) - 64'sd32768);
        t = longint'(margin_reg) + ((d * c) >>> 16);
        h = (t < 0) ? 0 : t;
        if (h > S32_MAX) h = S32_MAX;
        if (hinge_acc + longint'(h) > SUM_MAX) hinge_acc = SUM_MAX;
        else hinge_acc = hinge_acc + h;
        g = (h > 0) ? c / dv : 0;
        r.gradient = g[31:0];
        if (it.batch_end) begin
            q = hinge_acc / longint'(dv * ln);
            if (q > (64'd1 << 40)) q = 64'd1 << 40;
            ls = sat32(64'sd32768 - longint'(margin_reg) + longint'(q));
            r.loss = ls[31:0];
            r.loss_valid = 1'b1;
            hinge_acc = 0;
        end
        return 1'b1;
    endfunction

    task automatic offer(input thl_pkg::t_in_item it, input bit typed,
                         input thl_pkg::t_out_item want);
        thl_pkg::t_out_item r;
        bit        has;
        int        n;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 19);
            @(negedge i_clk) push <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        has = hinge_predict(it, r);
        if (it.operation == thl_pkg::OP_WRITE) n_wr++;
        else n_elem++;
        if (has) begin
            if (r.loss_valid) n_loss++;
            grad_loss_q.insert(grad_loss_q.size(), typed ? want : r);
        end
    endtask

    task automatic settle();
        @(negedge i_clk) push <= 1'b0;
        wait (grad_loss_q.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic reg_access(input logic [1:0] idx, input bit wr, input logic [31:0] data);
        logic [31:0] want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk) penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        if (wr) begin
            case (idx)
                thl_pkg::REG_MARGIN: margin_reg = data;
                thl_pkg::REG_BATCH:  batch_reg  = data[10:0];
                thl_pkg::REG_LENGTH: length_reg = data[8:0];
                default: ;
            endcase
        end else begin
            case (idx)
                thl_pkg::REG_MARGIN: want = margin_reg;
                thl_pkg::REG_BATCH:  want = {21'd0, batch_reg};
                default:             want = {23'd0, length_reg};
            endcase
            if (prdata !== want) begin
                $error("register %0d: expected %h, got %h", idx, want, prdata);
                errors++;
            end
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_config(input logic [31:0] m, input logic [31:0] b,
                                input logic [31:0] l);
        settle();
        reg_access(thl_pkg::REG_MARGIN, 1'b1, m);
        reg_access(thl_pkg::REG_BATCH, 1'b1, b);
        reg_access(thl_pkg::REG_LENGTH, 1'b1, l);
        reg_access(REG_SPARE, 1'b1, $urandom);
        reg_access(thl_pkg::REG_MARGIN, 1'b0, '0);
        reg_access(thl_pkg::REG_BATCH, 1'b0, '0);
        reg_access(thl_pkg::REG_LENGTH, 1'b0, '0);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'd32768 + $urandom_range(0, 8192) - 4096;
            2: return $urandom_range(0, 131072);
            3: return -$urandom_range(0, 131072);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_code();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'd65536;
            2: return $urandom_range(0, 65536);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_stream(input int count, input bit with_hold);
        thl_pkg::t_in_item it;
        logic [15:0] a;
        for (int k = 0; k < count; k++) begin
            if (with_hold && k == count / 2) hold_left = 400;
            if (written_addrs.size() < 4 || $urandom_range(0, 7) == 0) begin
                it = '{thl_pkg::OP_WRITE, 8'($urandom), 8'($urandom), pick_code(),
                       1'($urandom)};
            end else begin
                a = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                it = '{thl_pkg::OP_ELEM, a[15:8], a[7:0], pick_value(),
                       $urandom_range(0, 5) == 0};
            end
            offer(it, 1'b0, '0);
        end
    endtask

    task automatic add_row(input logic op, input logic [7:0] cls, input logic [7:0] pos,
                           input logic [31:0] val, input logic be, input bit typed,
                           input logic [31:0] grad, input logic [31:0] loss, input logic lv);
        t_row r;
        r.it = '{op, cls, pos, val, be};
        r.typed = typed;
        r.want = '{grad, loss, lv};
        rows.insert(rows.size(), r);
    endtask

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("tb_target_code_hinge_loss_unit NOT OK");
            $finish;
        end
    end

    initial forever begin
        @(negedge i_clk);
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            pop <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 19) - 1;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        thl_pkg::t_out_item w;
        if (i_rst_n && pop && !empty) begin
            if (grad_loss_q.size() == 0) begin
                $error("unexpected result %h", o_result);
                errors++;
            end else begin
                w = grad_loss_q.pop_front();
                n_checked++;
                if (o_result.gradient !== w.gradient) begin
                    $error("gradient: expected %h, got %h", w.gradient, o_result.gradient);
                    errors++;
                end
                if (o_result.loss !== w.loss) begin
                    $error("loss: expected %h, got %h", w.loss, o_result.loss);
                    errors++;
                end
                if (o_result.loss_valid !== w.loss_valid) begin
                    $error("loss_valid: expected %b, got %b", w.loss_valid,
                           o_result.loss_valid);
                    errors++;
                end
            end
        end
    end

    initial begin
        add_row(thl_pkg::OP_WRITE, 8'd0, 8'd0, 32'd0, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_WRITE, 8'd255, 8'd255, 32'd65536, 1'b1, 0, 0, 0, 0);
        add_row(thl_pkg::OP_WRITE, 8'd1, 8'd2, 32'h7FFF_FFFF, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_WRITE, 8'd2, 8'd1, 32'h8000_0000, 1'b1, 0, 0, 0, 0);
        add_row(thl_pkg::OP_WRITE, 8'h5A, 8'hA5, 32'd16384, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_WRITE, 8'hA5, 8'h5A, 32'hFFFF_0000, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'd0, 8'd0, 32'd32768, 1'b0, 1, 32'd65536, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'd0, 8'd0, 32'd32768, 1'b1, 1, 32'd65536, 32'd257, 1);
        add_row(thl_pkg::OP_ELEM, 8'd255, 8'd255, 32'd32768, 1'b0, 1, -32'sd65536, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'd255, 8'd255, 32'h7FFF_FFFF, 1'b0, 1, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'd1, 8'd2, 32'h8000_0000, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'd1, 8'd2, 32'h7FFF_FFFF, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'd2, 8'd1, 32'h7FFF_FFFF, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'd2, 8'd1, 32'h8000_0000, 1'b1, 0, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'h5A, 8'hA5, 32'd0, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'hA5, 8'h5A, 32'hDEAD_BEEF, 1'b0, 0, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'hA5, 8'h5A, 32'd65536, 1'b1, 0, 0, 0, 0);
        add_row(thl_pkg::OP_ELEM, 8'd0, 8'd0, 32'h8000_0000, 1'b1, 0, 0, 0, 0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (rows[i]) offer(rows[i].it, rows[i].typed, rows[i].want);
        run_stream(200, 1'b1);
        apply_config(32'h8000_0000, 32'd0, 32'd0);
        run_stream(200, 1'b0);
        apply_config(32'h7FFF_FFFF, 32'd2047, 32'd511);
        run_stream(200, 1'b1);
        apply_config(32'd0, 32'd1024, 32'd256);
        run_stream(200, 1'b0);
        apply_config($urandom_range(0, 131072), $urandom_range(1, 16),
                     $urandom_range(1, 32));
        run_stream(200, 1'b0);
        apply_config($urandom, $urandom_range(0, 2047), $urandom_range(0, 511));
        no_idle = 1'b1;
        run_stream(200, 1'b0);
        settle();

        $display("covered %0d elements, %0d table writes, %0d batch losses; %0d results checked",
                 n_elem, n_wr, n_loss, n_checked);
        $display("register settings: reset, both margin extremes, batch/length 0 and max");
        if (errors == 0) begin
            $display("tb_target_code_hinge_loss_unit OK");
        end else begin
            $display("tb_target_code_hinge_loss_unit NOT OK");
        end
        $finish;
    end

endmodule
